FILE: rtl/core/lsod_pkg.sv
`default_nettype none
// ============================================================================
// lsod_pkg - shared types and constants for the lidar sector obstacle detector
// Holds the configuration record, the queue entry, the result record and the
// register and steering codes used by the front, queue, back and top level.
// ============================================================================
package lsod_pkg;

    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 9;
    localparam int SENSOR_W = 7;
    localparam int SUM_W    = 32;
    localparam int NUM_SEC  = 3;
    localparam int Q_DEPTH  = 4;
    localparam int FULL_TURN = 360;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_ACTIVATION = 2'd0,
        REG_SENSOR_ANG = 2'd1,
        REG_RANGE_MAX  = 2'd2,
        REG_COLLISION  = 2'd3
    } t_reg_idx;

    // Steering choice
    typedef enum logic [1:0] {
        STEER_FWD = 2'd0,
        STEER_CCW = 2'd1,
        STEER_CW  = 2'd2
    } t_steer;

    // Sector order inside the hit vector
    localparam int SEC_LEFT  = 0;
    localparam int SEC_FRONT = 1;
    localparam int SEC_RIGHT = 2;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_angle_deg;
        logic [RANGE_W-1:0]  range_max_mm;
        logic [RANGE_W-1:0]  collision_mm;
    } t_cfg;

    // One classified sample travelling from front to back
    typedef struct packed {
        logic [RANGE_W-1:0] val;
        logic [NUM_SEC-1:0] hit;
        logic               coll;
        logic               last;
    } t_qent;

    typedef struct packed {
        logic   left_near;
        logic   front_near;
        logic   right_near;
        logic   collision;
        t_steer steer;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/core/lsod_front.sv
`default_nettype none
// ============================================================================
// lsod_front - sample intake and classification
// Registers each sample, works out its sector membership and substituted
// value, then checks the collision step and pushes the entry to the queue.
// ============================================================================
module lsod_front
    import lsod_pkg::*;
#(
    parameter int SECTOR_WIDTH   = 5,
    parameter int COLLISION_STEP = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [RANGE_W-1:0] i_range_mm,
    input  wire logic               i_out_of_range,
    input  wire logic [ANGLE_W-1:0] i_angle_deg,
    input  wire logic               i_last,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output t_qent                   o_push_data
);

    localparam int HALF    = SECTOR_WIDTH / 2;
    localparam int T_W     = 11;
    localparam int RECIP   = (65536 + COLLISION_STEP - 1) / COLLISION_STEP;
    localparam int RECIP_W = 17;
    localparam int PROD_W  = ANGLE_W + RECIP_W;
    localparam int STEP_W  = 5;
    localparam int CHK_W   = ANGLE_W + STEP_W + 1;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [STEP_W-1:0]  STEP_C  = STEP_W'(COLLISION_STEP);

    logic                   r_valid, n_valid;
    logic [RANGE_W-1:0]     r_val;
    logic [NUM_SEC-1:0]     r_hit;
    logic                   r_coll_cand;
    logic [ANGLE_W-1:0]     r_angle;
    logic [ANGLE_W-1:0]     r_quot;
    logic                   r_last;

    logic                   accept;
    logic                   advance;
    logic                   in_turn;
    logic [ANGLE_W-1:0]     centre [NUM_SEC];
    logic [NUM_SEC-1:0]     hit;
    logic [PROD_W-1:0]      prod;
    logic [CHK_W-1:0]       chk;

    // Sector offset, wrapped into 0..359 with at most two subtracts
    function automatic logic in_sector(input logic [ANGLE_W-1:0] a,
                                       input logic [ANGLE_W-1:0] c);
        logic [T_W-1:0] t;
        logic [T_W-1:0] off;
        t = T_W'(a) + T_W'(HALF) + T_W'(FULL_TURN) - T_W'(c);
        if (t >= T_W'(2 * FULL_TURN)) begin
            off = t - T_W'(2 * FULL_TURN);
        end else if (t >= T_W'(FULL_TURN)) begin
            off = t - T_W'(FULL_TURN);
        end else begin
            off = t;
        end
        return off < T_W'(SECTOR_WIDTH);
    endfunction

    always_comb begin
        centre[SEC_LEFT]  = ANGLE_W'(i_cfg.sensor_angle_deg);
        centre[SEC_FRONT] = '0;
        centre[SEC_RIGHT] = (i_cfg.sensor_angle_deg == '0) ? '0 :
                            ANGLE_W'(FULL_TURN) - ANGLE_W'(i_cfg.sensor_angle_deg);
    end

    assign in_turn = i_angle_deg < ANGLE_W'(FULL_TURN);

    always_comb begin
        for (int k = 0; k < NUM_SEC; k++) begin
            hit[k] = in_turn && in_sector(i_angle_deg, centre[k]);
        end
    end

    // Quotient by reciprocal; exact for every 9-bit angle
    assign prod = PROD_W'(i_angle_deg) * PROD_W'(RECIP_C);

    assign advance    = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val       <= i_out_of_range ? i_cfg.range_max_mm : i_range_mm;
            r_hit       <= hit;
            r_coll_cand <= in_turn && !i_out_of_range && (i_range_mm <= i_cfg.collision_mm);
            r_angle     <= i_angle_deg;
            r_quot      <= prod[16 +: ANGLE_W];
            r_last      <= i_last;
        end
    end

    // Angle is on a collision step when quotient times step gives it back
    assign chk = CHK_W'(r_quot) * CHK_W'(STEP_C);

    assign o_push           = advance;
    assign o_push_data.val  = r_val;
    assign o_push_data.hit  = r_hit;
    assign o_push_data.coll = r_coll_cand && (chk == CHK_W'(r_angle));
    assign o_push_data.last = r_last;

endmodule
`default_nettype wire

FILE: rtl/core/lsod_queue.sv
`default_nettype none
// ============================================================================
// lsod_queue - short queue between front and back
// Small register queue of classified samples; first word shown on the read
// side while not empty.
// ============================================================================
module lsod_queue
    import lsod_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_push_data,
    input  wire logic  i_pop,
    output t_qent      o_pop_data,
    output logic       o_full,
    output logic       o_empty
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_qent              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = r_cnt == CNT_W'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_pop_data = r_mem[r_rd];

endmodule
`default_nettype wire

FILE: rtl/core/lsod_back.sv
`default_nettype none
// ============================================================================
// lsod_back - sector accumulation and scan decision
// Adds each sample into the sectors it hits, and on the last sample of a
// scan compares the sums against the limit, registers the result and clears.
// ============================================================================
module lsod_back
    import lsod_pkg::*;
#(
    parameter int LIM_W = 19
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_qent            i_pop_data,
    input  wire logic             i_q_empty,
    output logic                  o_pop,
    input  wire logic [LIM_W-1:0] i_limit,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_result               o_result
);

    logic [SUM_W-1:0] r_sum [NUM_SEC];
    logic [SUM_W-1:0] n_sum [NUM_SEC];
    logic             r_coll, n_coll;
    logic             r_out_valid, n_out_valid;
    t_result          r_result;
    t_result          res;
    logic             out_free;
    logic             fin;
    logic             coll_all;
    logic [NUM_SEC-1:0] near;

    // A held result only blocks the next last sample; others keep accumulating
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = !i_q_empty && (out_free || !i_pop_data.last);
    assign fin      = o_pop && i_pop_data.last;
    assign coll_all = r_coll || i_pop_data.coll;

    always_comb begin
        for (int k = 0; k < NUM_SEC; k++) begin
            n_sum[k] = r_sum[k] + (i_pop_data.hit[k] ? SUM_W'(i_pop_data.val) : '0);
            near[k]  = n_sum[k] <= SUM_W'(i_limit);
        end
    end

    always_comb begin
        res.left_near  = near[SEC_LEFT];
        res.front_near = near[SEC_FRONT];
        res.right_near = near[SEC_RIGHT];
        res.collision  = coll_all;
        if (near[SEC_LEFT]) begin
            res.steer = STEER_CCW;
        end else if (near[SEC_FRONT] || near[SEC_RIGHT]) begin
            res.steer = STEER_CW;
        end else begin
            res.steer = STEER_FWD;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (fin) begin
            n_out_valid = 1'b1;
        end
        n_coll = r_coll;
        if (o_pop) begin
            n_coll = fin ? 1'b0 : coll_all;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_coll      <= 1'b0;
            for (int k = 0; k < NUM_SEC; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            r_coll      <= n_coll;
            if (o_pop) begin
                for (int k = 0; k < NUM_SEC; k++) begin
                    r_sum[k] <= fin ? '0 : n_sum[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_result <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule
`default_nettype wire

FILE: rtl/core/lidar_sector_obstacle_detect.sv
`default_nettype none
// ============================================================================
// lidar_sector_obstacle_detect - lidar sector obstacle detector, top level
// Sums three sectors of a lidar scan, flags near sectors and collisions and
// picks a steering direction at the end of every scan.
// ============================================================================
// Throughput: one sample per cycle, sustained, while the result side is not
//   held; the queue absorbs short stalls and the output register holds one
//   finished result while samples keep arriving.
// Result path: the last sample passes the intake register, the queue and the
//   result register before result valid when the queue is empty.
// Reset: synchronous, active low; clears sector sums, collision flag, queue
//   and valid flags, and loads the configuration registers with defaults.
// ============================================================================
module lidar_sector_obstacle_detect
    import lsod_pkg::*;
#(
    parameter int SECTOR_WIDTH   = 5,
    parameter int COLLISION_STEP = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // sample channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [RANGE_W-1:0] i_range_mm,
    input  wire logic               i_out_of_range,
    input  wire logic [ANGLE_W-1:0] i_angle_deg,
    input  wire logic               i_last,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_left_near,
    output logic                    o_front_near,
    output logic                    o_right_near,
    output logic                    o_collision,
    output logic [1:0]              o_steer,
    // configuration channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [RANGE_W-1:0] i_cfg_data
);

    // Limit is SECTOR_WIDTH times the activation distance
    localparam int LIM_W = RANGE_W + $clog2(SECTOR_WIDTH + 1);

    localparam logic [RANGE_W-1:0]  RST_ACT  = RANGE_W'(1000);
    localparam logic [SENSOR_W-1:0] RST_ANG  = SENSOR_W'(30);
    localparam logic [RANGE_W-1:0]  RST_RMAX = RANGE_W'(3500);
    localparam logic [RANGE_W-1:0]  RST_COLL = RANGE_W'(150);

    logic [RANGE_W-1:0]  r_activation;
    logic [SENSOR_W-1:0] r_sensor_angle;
    logic [RANGE_W-1:0]  r_range_max;
    logic [RANGE_W-1:0]  r_collision_mm;
    logic [LIM_W-1:0]    r_limit;
    logic                cfg_wr;
    t_cfg                cfg;

    logic    push;
    t_qent   push_data;
    logic    pop;
    t_qent   pop_data;
    logic    q_full;
    logic    q_empty;
    t_result result;

    // Configuration: always ready, one register per transfer
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_activation   <= RST_ACT;
            r_sensor_angle <= RST_ANG;
            r_range_max    <= RST_RMAX;
            r_collision_mm <= RST_COLL;
        end else if (cfg_wr) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ACTIVATION: r_activation   <= i_cfg_data;
                REG_SENSOR_ANG: r_sensor_angle <= i_cfg_data[SENSOR_W-1:0];
                REG_RANGE_MAX:  r_range_max    <= i_cfg_data;
                REG_COLLISION:  r_collision_mm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the scaled limit in a register fed from the activation register; it is
    // updated by the time a sample accepted with or after the write reaches the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_W'(RST_ACT) * LIM_W'(SECTOR_WIDTH);
        end else begin
            r_limit <= LIM_W'(r_activation) * LIM_W'(SECTOR_WIDTH);
        end
    end

    assign cfg.sensor_angle_deg = r_sensor_angle;
    assign cfg.range_max_mm     = r_range_max;
    assign cfg.collision_mm     = r_collision_mm;

    // Front: take samples, classify sector hits and collision step
    lsod_front #(
        .SECTOR_WIDTH   (SECTOR_WIDTH),
        .COLLISION_STEP (COLLISION_STEP)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_range_mm     (i_range_mm),
        .i_out_of_range (i_out_of_range),
        .i_angle_deg    (i_angle_deg),
        .i_last         (i_last),
        .i_cfg          (cfg),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    // Queue decouples intake from accumulation
    lsod_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    // Back: accumulate, decide at end of scan, hold the result
    lsod_back #(
        .LIM_W (LIM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_data  (pop_data),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .i_limit     (r_limit),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_left_near  = result.left_near;
    assign o_front_near = result.front_near;
    assign o_right_near = result.right_near;
    assign o_collision  = result.collision;
    assign o_steer      = result.steer;

endmodule
`default_nettype wire
